### sv/dqe_pkg.sv
// ----------------------------------------------------------------------------
// dqe_pkg: shared definitions for the bounded deque engine
// Command and status codes, cell operations and the cell control bundle.
// ----------------------------------------------------------------------------
package dqe_pkg;

    localparam int CAPACITY_DEF = 32;
    localparam int MAX_RESULTS  = 32;
    localparam int WORD_W       = 32;
    localparam int CMD_W        = 3;
    localparam int STATUS_W     = 2;

    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DUMP_FWD   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_DUMP_BWD   = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_SHIFT_UP,
        OP_SHIFT_DOWN,
        OP_PUSH_BACK,
        OP_ROT_FWD,
        OP_ROT_BWD
    } cell_op_t;

    // per-cell control: operation plus the cell's position flags
    typedef struct packed {
        cell_op_t op;
        logic     first;  // cell 0 (front slot)
        logic     valid;  // holds a word
        logic     tail;   // holds the back word
        logic     free;   // first empty slot
    } cell_ctl_t;

endpackage

### sv/dqe_cell.sv
// ----------------------------------------------------------------------------
// dqe_cell: one slot of the deque chain
// Holds one word and loads from a neighbor, the input or a wrap path.
// ----------------------------------------------------------------------------
module dqe_cell (
    input  logic                     clk,
    input  dqe_pkg::cell_ctl_t       ctl,
    input  logic [dqe_pkg::WORD_W-1:0] value,
    input  logic [dqe_pkg::WORD_W-1:0] left_data,
    input  logic [dqe_pkg::WORD_W-1:0] right_data,
    input  logic [dqe_pkg::WORD_W-1:0] head_data,
    output logic [dqe_pkg::WORD_W-1:0] data
);
    import dqe_pkg::*;

    logic [WORD_W-1:0] data_reg;
    logic [WORD_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        unique case (ctl.op)
            OP_HOLD:       data_next = data_reg;
            OP_SHIFT_UP:   data_next = ctl.first ? value : left_data;
            OP_SHIFT_DOWN: data_next = right_data;
            OP_PUSH_BACK:
            begin
                if (ctl.free)
                    data_next = value;
            end
            OP_ROT_FWD:
            begin
                if (ctl.valid)
                    data_next = ctl.tail ? head_data : right_data;
            end
            // cell 0 sees the back word on its left input
            OP_ROT_BWD:
            begin
                if (ctl.valid)
                    data_next = left_data;
            end
            default:       data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

### sv/bounded_deque_engine.sv
// Push and pop: a command is taken while the output slot is free; the result is
//   registered in the cycle after acceptance. Dump: the sequencer enters S_DUMP, then
//   words leave one per cycle while the output is not stalled, as the chain rotates.
// A stalled output holds the chain; the next command is taken once the dump ends.
// Reset (rst_n low, asynchronous) empties the deque and clears the output valid;
//   stored words are not cleared and are never read before being written.
// ----------------------------------------------------------------------------
// bounded_deque_engine: bounded double-ended queue of 32-bit words
// A row of cells holds the words in order, front in cell 0. Pushes and pops
// shift the row; dumps rotate the occupied part and emit from one end.
// ----------------------------------------------------------------------------
module bounded_deque_engine #(
    parameter int CAPACITY = dqe_pkg::CAPACITY_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [2:0] command, [34:3] value, [39:35] zero
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] word
    output logic [1:0]  m_tuser,   // [1:0] status
    output logic        m_tlast
);
    import dqe_pkg::*;

    localparam int CntW = $clog2(CAPACITY + 1);
    localparam logic [CntW-1:0] Cap = CntW'(CAPACITY);
    // dumps emit at most this many words
    localparam logic [CntW-1:0] MaxRes =
        (CAPACITY > MAX_RESULTS) ? CntW'(MAX_RESULTS) : CntW'(CAPACITY);

    // sequencer states
    localparam logic S_IDLE = 1'b0;
    localparam logic S_DUMP = 1'b1;

    logic                state_reg, state_next;
    logic                bwd_reg, bwd_next;
    logic [CntW-1:0]     occ_reg, occ_next;
    logic [CntW-1:0]     cnt_reg, cnt_next;

    // output register
    logic                out_valid_reg, out_valid_next;
    logic [WORD_W-1:0]   word_reg, word_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                last_reg, last_next;

    logic                slot_free;
    logic                accept;
    logic [CMD_W-1:0]    cmd;
    logic [WORD_W-1:0]   value;
    cell_op_t            op;

    logic [WORD_W-1:0]   cell_data [CAPACITY];
    logic [WORD_W-1:0]   head_data;
    logic [WORD_W-1:0]   tail_data;
    logic [CAPACITY-1:0] tail_vec;
    logic [CntW-1:0]     dump_n;

    assign cmd       = s_tdata[CMD_W-1:0];
    assign value     = s_tdata[CMD_W +: WORD_W];
    assign slot_free = !out_valid_reg || m_tready;
    assign s_tready  = (state_reg == S_IDLE) && slot_free;
    assign accept    = s_tvalid && s_tready;
    assign head_data = cell_data[0];
    assign dump_n    = (occ_reg > MaxRes) ? MaxRes : occ_reg;

    // back word: one-hot tail flag selects it out of the row
    always_comb
    begin
        tail_data = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            tail_data = tail_data | (cell_data[i] & {WORD_W{tail_vec[i]}});
        end
    end

    // the cell row
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        cell_ctl_t         ctl;
        logic [WORD_W-1:0] left_in;
        logic [WORD_W-1:0] right_in;

        assign tail_vec[g] = (occ_reg == CntW'(g + 1));
        assign ctl.op      = op;
        assign ctl.first   = (g == 0);
        assign ctl.valid   = (occ_reg > CntW'(g));
        assign ctl.tail    = tail_vec[g];
        assign ctl.free    = (occ_reg == CntW'(g));

        if (g == 0)
        begin : g_left_wrap
            assign left_in = tail_data;
        end
        else
        begin : g_left
            assign left_in = cell_data[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_right_end
            assign right_in = cell_data[g];
        end
        else
        begin : g_right
            assign right_in = cell_data[g+1];
        end

        dqe_cell u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .value      (value),
            .left_data  (left_in),
            .right_data (right_in),
            .head_data  (head_data),
            .data       (cell_data[g])
        );
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        bwd_next       = bwd_reg;
        occ_next       = occ_reg;
        cnt_next       = cnt_reg;
        op             = OP_HOLD;
        out_valid_next = out_valid_reg && !m_tready;
        word_next      = word_reg;
        status_next    = status_reg;
        last_next      = last_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    word_next   = '0;
                    status_next = ST_OK;
                    last_next   = 1'b1;
                    unique case (cmd) inside
                        CMD_PUSH_FRONT, CMD_PUSH_BACK:
                        begin
                            out_valid_next = 1'b1;
                            if (occ_reg == Cap)
                                status_next = ST_FULL;
                            else
                            begin
                                op       = (cmd == CMD_PUSH_FRONT) ? OP_SHIFT_UP
                                                                   : OP_PUSH_BACK;
                                occ_next = occ_reg + 1'b1;
                            end
                        end
                        CMD_POP_FRONT, CMD_POP_BACK:
                        begin
                            out_valid_next = 1'b1;
                            if (occ_reg == '0)
                                status_next = ST_EMPTY;
                            else
                            begin
                                if (cmd == CMD_POP_FRONT)
                                begin
                                    word_next = head_data;
                                    op        = OP_SHIFT_DOWN;
                                end
                                else
                                    word_next = tail_data;
                                occ_next = occ_reg - 1'b1;
                            end
                        end
                        CMD_DUMP_FWD, CMD_DUMP_BWD:
                        begin
                            if (occ_reg == '0)
                            begin
                                out_valid_next = 1'b1;
                                status_next    = ST_EMPTY;
                            end
                            else
                            begin
                                state_next = S_DUMP;
                                bwd_next   = (cmd == CMD_DUMP_BWD);
                                cnt_next   = '0;
                            end
                        end
                        default:
                        begin
                            // unused codes: no result, the deque is unchanged
                        end
                    endcase
                end
            end
            S_DUMP:
            begin
                if (slot_free)
                begin
                    // rotation runs over the whole occupancy so the row ends
                    // where it started; only the first dump_n steps emit
                    op = bwd_reg ? OP_ROT_BWD : OP_ROT_FWD;
                    if (cnt_reg < dump_n)
                    begin
                        out_valid_next = 1'b1;
                        word_next      = bwd_reg ? tail_data : head_data;
                        status_next    = ST_OK;
                        last_next      = (cnt_reg + 1'b1 == dump_n);
                    end
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg + 1'b1 == occ_reg)
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            bwd_reg       <= 1'b0;
            occ_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bwd_reg       <= bwd_next;
            occ_reg       <= occ_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg   <= word_next;
        status_reg <= status_next;
        last_reg   <= last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = word_reg;
    assign m_tuser  = status_reg;
    assign m_tlast  = last_reg;

`ifndef SYNTH
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= Cap)
        else $error("occupancy above capacity");

    a_dump_holds_occ: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DUMP) |=> (occ_reg == $past(occ_reg)))
        else $error("occupancy changed during dump");

    a_dump_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DUMP) |-> (cnt_reg < occ_reg))
        else $error("dump step beyond occupancy");

    a_error_word_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == ST_EMPTY || m_tuser == ST_FULL))
            |-> (m_tdata == '0 && m_tlast))
        else $error("error result carries a word or is not last");
`endif

endmodule
